>>> sv/ilp_pkg.sv
package ilp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIGN,
        PH_SPACE,
        PH_ZERO,
        PH_FIRST,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_8,
        RADIX_10,
        RADIX_16
    } radix_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_DIGIT,
        ST_BAD_DIGIT,
        ST_OVERFLOW,
        ST_UNDERFLOW,
        ST_RANGE
    } status_t;

    typedef struct packed {
        logic               start_req;
        logic [7:0]         char_in;
        logic               end_of_input;
        logic signed [31:0] min_limit;
        logic signed [31:0] max_limit;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
        status_t            status;
    } result_t;

endpackage

>>> sv/ilp_core.sv
module ilp_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  ilp_pkg::item_t  item,
    output ilp_pkg::result_t res
);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam logic signed [37:0] ACC_MAX = 38'sd2147483647;
    localparam logic signed [37:0] ACC_MIN = -38'sd2147483648;

    ilp_pkg::phase_t    phase_reg, phase_next;
    logic               neg_reg, neg_next;
    ilp_pkg::radix_t    radix_reg, radix_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] lo_reg, lo_next;
    logic signed [31:0] hi_reg, hi_next;

    ilp_pkg::phase_t    ph_eff, ph_work;
    logic               neg_eff;
    ilp_pkg::radix_t    rad_eff, rad_use;
    logic signed [31:0] acc_eff, lo_eff, hi_eff;

    logic               has_char, is_plus, is_minus, is_space, is_zero, is_x, sign_taken;
    logic               hex_ok, digit_ok, take_ok, range_bad;
    logic [3:0]         hex_val;
    logic signed [37:0] acc_ext, prod, sum;
    ilp_pkg::status_t   take_status;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // A start item restarts the parse before its character is looked at.
    assign ph_eff  = item.start_req ? ilp_pkg::PH_SIGN  : phase_reg;
    assign neg_eff = item.start_req ? 1'b0              : neg_reg;
    assign rad_eff = item.start_req ? ilp_pkg::RADIX_10 : radix_reg;
    assign acc_eff = item.start_req ? 32'sd0            : acc_reg;
    assign lo_eff  = item.start_req ? item.min_limit    : lo_reg;
    assign hi_eff  = item.start_req ? item.max_limit    : hi_reg;

    assign has_char = !item.end_of_input;
    assign is_plus  = has_char && item.char_in == CH_PLUS;
    assign is_minus = has_char && item.char_in == CH_MINUS;
    assign is_space = has_char && (item.char_in == CH_SPACE ||
                      (item.char_in >= CH_TAB && item.char_in <= CH_CR));
    assign is_zero  = has_char && item.char_in == CH_ZERO;
    assign is_x     = has_char && (item.char_in == CH_LX || item.char_in == CH_UX);
    assign {hex_ok, hex_val} = has_char ? hex_decode(item.char_in) : 5'd0;

    // A non-sign character in the sign phase is handled as in the space phase.
    assign sign_taken = ph_eff == ilp_pkg::PH_SIGN && (is_plus || is_minus);
    assign ph_work    = (ph_eff == ilp_pkg::PH_SIGN) ? ilp_pkg::PH_SPACE : ph_eff;
    assign rad_use    = (ph_work == ilp_pkg::PH_ZERO) ? ilp_pkg::RADIX_8 : rad_eff;

    always_comb begin
        acc_ext = 38'(acc_eff);
        case (rad_use)
            ilp_pkg::RADIX_8: begin
                digit_ok = !hex_val[3];
                prod     = acc_ext <<< 3;
            end
            ilp_pkg::RADIX_16: begin
                digit_ok = 1'b1;
                prod     = acc_ext <<< 4;
            end
            default: begin
                digit_ok = hex_val < 4'd10;
                prod     = (acc_ext <<< 3) + (acc_ext <<< 1);
            end
        endcase
    end

    assign sum = neg_eff ? prod - $signed({34'd0, hex_val}) : prod + $signed({34'd0, hex_val});

    always_comb begin
        if (!digit_ok) begin
            take_status = ilp_pkg::ST_BAD_DIGIT;
        end else if (!neg_eff && sum > ACC_MAX) begin
            take_status = ilp_pkg::ST_OVERFLOW;
        end else if (neg_eff && sum < ACC_MIN) begin
            take_status = ilp_pkg::ST_UNDERFLOW;
        end else begin
            take_status = ilp_pkg::ST_OK;
        end
    end

    assign take_ok   = take_status == ilp_pkg::ST_OK;
    assign range_bad = acc_eff > hi_eff || acc_eff < lo_eff;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            if (ph_eff == ilp_pkg::PH_IDLE) begin
                phase_next = ilp_pkg::PH_IDLE;
            end else if (sign_taken) begin
                phase_next = ilp_pkg::PH_SPACE;
            end else begin
                case (ph_work)
                    ilp_pkg::PH_SPACE: begin
                        if (is_space) begin
                            phase_next = ilp_pkg::PH_SPACE;
                        end else if (is_zero) begin
                            phase_next = ilp_pkg::PH_ZERO;
                        end else if (hex_ok && take_ok) begin
                            phase_next = ilp_pkg::PH_DIGITS;
                        end else begin
                            phase_next = ilp_pkg::PH_IDLE;
                        end
                    end
                    ilp_pkg::PH_ZERO: begin
                        if (is_x) begin
                            phase_next = ilp_pkg::PH_FIRST;
                        end else if (hex_ok && take_ok) begin
                            phase_next = ilp_pkg::PH_DIGITS;
                        end else begin
                            phase_next = ilp_pkg::PH_IDLE;
                        end
                    end
                    ilp_pkg::PH_FIRST, ilp_pkg::PH_DIGITS: begin
                        if (hex_ok && take_ok) begin
                            phase_next = ilp_pkg::PH_DIGITS;
                        end else begin
                            phase_next = ilp_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = ilp_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Datapath updates and result.
    always_comb begin
        neg_next   = neg_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        res.valid  = 1'b0;
        res.value  = 32'sd0;
        res.status = ilp_pkg::ST_OK;
        if (step) begin
            neg_next   = neg_eff;
            radix_next = rad_eff;
            acc_next   = acc_eff;
            lo_next    = lo_eff;
            hi_next    = hi_eff;
            if (ph_eff != ilp_pkg::PH_IDLE) begin
                if (sign_taken) begin
                    neg_next = is_minus;
                end else begin
                    case (ph_work)
                        ilp_pkg::PH_SPACE, ilp_pkg::PH_FIRST: begin
                            if (ph_work == ilp_pkg::PH_SPACE && (is_space || is_zero)) begin
                                res.valid = 1'b0;
                            end else if (!hex_ok) begin
                                res.valid  = 1'b1;
                                res.status = ilp_pkg::ST_NO_DIGIT;
                            end else if (take_ok) begin
                                acc_next = sum[31:0];
                            end else begin
                                res.valid  = 1'b1;
                                res.status = take_status;
                            end
                        end
                        ilp_pkg::PH_ZERO, ilp_pkg::PH_DIGITS: begin
                            if (ph_work == ilp_pkg::PH_ZERO && is_x) begin
                                radix_next = ilp_pkg::RADIX_16;
                            end else if (!hex_ok) begin
                                res.valid = 1'b1;
                                if (range_bad) begin
                                    res.status = ilp_pkg::ST_RANGE;
                                end else begin
                                    res.value = acc_eff;
                                end
                            end else begin
                                radix_next = rad_use;
                                if (take_ok) begin
                                    acc_next = sum[31:0];
                                end else begin
                                    res.valid  = 1'b1;
                                    res.status = take_status;
                                end
                            end
                        end
                        default: begin
                            res.valid = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ilp_pkg::PH_IDLE;
            neg_reg   <= 1'b0;
            radix_reg <= ilp_pkg::RADIX_10;
            acc_reg   <= 32'sd0;
            lo_reg    <= 32'sd0;
            hi_reg    <= 32'sd0;
        end else begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            radix_reg <= radix_next;
            acc_reg   <= acc_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
        end
    end

    a_result_ends_parse: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.valid |=> phase_reg == ilp_pkg::PH_IDLE)
        else $error("parser did not return to idle after a result");

    a_error_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.status != ilp_pkg::ST_OK |-> res.value == 32'sd0)
        else $error("error result carries a nonzero value");

    a_acc_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == ilp_pkg::PH_DIGITS |-> (neg_reg ? (acc_reg[31] || acc_reg == 32'sd0)
                                                     : !acc_reg[31]))
        else $error("accumulator sign disagrees with the literal's sign");

endmodule

>>> sv/integer_literal_parser_unit.sv
// A character transfer is registered in the input register and parsed once the
// result register can take its result; a result (if any) is registered there
// and shown on m_valid. Throughput: one character per cycle while m_ready is
// high; the digit accumulate (shift-add by 8, 10 or 16, range check) is combinational.
// Reset: aresetn is synchronous, active low; it empties both registers and
// returns the parser to idle with radix ten and zero bounds.
module integer_literal_parser_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_start_req,
    input  logic [7:0]         s_char_in,
    input  logic               s_end_of_input,
    input  logic signed [31:0] s_min_limit,
    input  logic signed [31:0] s_max_limit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_parsed_value,
    output logic [2:0]         m_status
);

    // Input register: one character waiting to be parsed.
    logic             in_valid_reg, in_valid_next;
    ilp_pkg::item_t   item_reg, item_next;

    // Result register: one finished result waiting for its transfer.
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] value_reg, value_next;
    ilp_pkg::status_t   status_reg, status_next;

    logic             step;
    ilp_pkg::result_t res;

    // Parse the held character once the result register can take whatever it
    // may produce: either it is empty or its result leaves in this cycle.
    assign step    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    ilp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .res     (res)
    );

    always_comb begin
        // Advance the input register on a transfer, drop it once parsed.
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (s_valid && s_ready) begin
            in_valid_next          = 1'b1;
            item_next.start_req    = s_start_req;
            item_next.char_in      = s_char_in;
            item_next.end_of_input = s_end_of_input;
            item_next.min_limit    = s_min_limit;
            item_next.max_limit    = s_max_limit;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        // Load a new result, or drop the old one after its transfer.
        m_valid_next = m_valid_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        if (step && res.valid) begin
            m_valid_next = 1'b1;
            value_next   = res.value;
            status_next  = res.status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        item_reg   <= item_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_parsed_value = value_reg;
    assign m_status       = status_reg;

    // A held character is never lost while the output side stalls.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg)
        else $error("pending character dropped without being parsed");

    // A waiting result is not overwritten by a new one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !step)
        else $error("parser advanced while a result was stalled");

    // A result shows up only after a character was parsed.
    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(step))
        else $error("result appeared without a parse step");

endmodule

>>> tb/sv/literal_checker.sv
module literal_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_start_req,
    input  logic [7:0]         s_char_in,
    input  logic               s_end_of_input,
    input  logic signed [31:0] s_min_limit,
    input  logic signed [31:0] s_max_limit,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_parsed_value,
    input  logic [2:0]         m_status,
    output int                 fail_count,
    output int                 pending_count
);

    localparam int     MAX_REPORTS = 10;
    localparam int     NO_CHAR     = 256;
    localparam longint I32_MIN     = -64'sd2147483648;
    localparam longint I32_MAX     = 64'sd2147483647;

    typedef struct {
        logic signed [31:0] value;
        ilp_pkg::status_t   status;
    } literal_result_t;

    literal_result_t expected_q[$];
    literal_result_t want;

    ilp_pkg::phase_t parse_phase;
    bit              parse_negative;
    int              parse_radix;
    longint          parse_accum;
    longint          low_bound;
    longint          high_bound;

    function automatic int digit_of(int c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // Queue the result and drop back to idle.
    function automatic void close_literal(ilp_pkg::status_t st, longint val);
        expected_q.push_back('{value: val[31:0], status: st});
        parse_phase = ilp_pkg::PH_IDLE;
    endfunction

    function automatic void range_check();
        if (parse_accum > high_bound || parse_accum < low_bound)
            close_literal(ilp_pkg::ST_RANGE, 0);
        else
            close_literal(ilp_pkg::ST_OK, parse_accum);
    endfunction

    function automatic void accumulate(int d);
        longint v;
        if (d >= parse_radix) begin
            close_literal(ilp_pkg::ST_BAD_DIGIT, 0);
            return;
        end
        v = parse_accum * parse_radix;
        if (parse_negative) begin
            v = v - d;
            if (v < I32_MIN) begin
                close_literal(ilp_pkg::ST_UNDERFLOW, 0);
                return;
            end
        end else begin
            v = v + d;
            if (v > I32_MAX) begin
                close_literal(ilp_pkg::ST_OVERFLOW, 0);
                return;
            end
        end
        parse_accum = v;
        parse_phase = ilp_pkg::PH_DIGITS;
    endfunction

    function automatic void parse_char(bit start, logic [7:0] ch, bit at_eoi,
                                       logic signed [31:0] lo, logic signed [31:0] hi);
        int c;
        int d;
        if (start) begin
            parse_phase    = ilp_pkg::PH_SIGN;
            parse_negative = 1'b0;
            parse_radix    = 10;
            parse_accum    = 0;
            low_bound      = longint'(lo);
            high_bound     = longint'(hi);
        end
        if (parse_phase == ilp_pkg::PH_IDLE) return;
        c = at_eoi ? NO_CHAR : int'(ch);
        d = digit_of(c);
        if (parse_phase == ilp_pkg::PH_SIGN) begin
            parse_phase = ilp_pkg::PH_SPACE;
            if (c == "-" || c == "+") begin
                parse_negative = (c == "-");
                return;
            end
        end
        case (parse_phase)
            ilp_pkg::PH_SPACE: begin
                // skip space and tab through carriage return
                if (c == " " || (c >= 8'h09 && c <= 8'h0D)) return;
                if (c == "0") begin
                    parse_phase = ilp_pkg::PH_ZERO;
                    return;
                end
                if (d < 0) close_literal(ilp_pkg::ST_NO_DIGIT, 0);
                else accumulate(d);
            end
            ilp_pkg::PH_ZERO: begin
                if (c == "x" || c == "X") begin
                    parse_radix = 16;
                    parse_phase = ilp_pkg::PH_FIRST;
                end else if (d < 0) begin
                    range_check();
                end else begin
                    parse_radix = 8;
                    accumulate(d);
                end
            end
            ilp_pkg::PH_FIRST: begin
                if (d < 0) close_literal(ilp_pkg::ST_NO_DIGIT, 0);
                else accumulate(d);
            end
            default: begin
                if (d < 0) range_check();
                else accumulate(d);
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_phase    = ilp_pkg::PH_IDLE;
            parse_negative = 1'b0;
            parse_radix    = 10;
            parse_accum    = 0;
            low_bound      = 0;
            high_bound     = 0;
            expected_q.delete();
        end else begin
            // compare before predicting: a result never stems from this edge's input
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected result: value %0d status %0d",
                                 m_parsed_value, m_status);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_parsed_value !== want.value || m_status !== want.status) begin
                        if (fail_count < MAX_REPORTS)
                            $display({"mismatch: expected value %0d status %0d, ",
                                      "got value %0d status %0d"},
                                     want.value, want.status, m_parsed_value, m_status);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                parse_char(s_start_req, s_char_in, s_end_of_input, s_min_limit, s_max_limit);
        end
        pending_count = expected_q.size();
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int TARGET_CHARS    = 550;
    // start the long receiver hold-off once this many characters have gone in
    localparam int HOLD_OFF_AFTER  = 200;
    localparam int HOLD_OFF_CYCLES = 300;
    // input and result registers; let the pipe settle before the verdict
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 200000;

    localparam logic signed [31:0] I32_LO = 32'sh8000_0000;
    localparam logic signed [31:0] I32_HI = 32'sh7FFF_FFFF;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // Drive every input to a known value from time zero.
    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_start_req    = 1'b0;
    logic [7:0]         s_char_in      = 8'd0;
    logic               s_end_of_input = 1'b0;
    logic signed [31:0] s_min_limit    = 32'sd0;
    logic signed [31:0] s_max_limit    = 32'sd0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [31:0] m_parsed_value;
    logic [2:0]         m_status;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int sent_count  = 0;
    int live_chars  = 0;

    // Character stream, built up front and replayed by the sender.
    ilp_pkg::item_t char_q[$];

    always #CLK_HALF aclk = ~aclk;

    integer_literal_parser_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_req    (s_start_req),
        .s_char_in      (s_char_in),
        .s_end_of_input (s_end_of_input),
        .s_min_limit    (s_min_limit),
        .s_max_limit    (s_max_limit),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parsed_value (m_parsed_value),
        .m_status       (m_status)
    );

    literal_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_req    (s_start_req),
        .s_char_in      (s_char_in),
        .s_end_of_input (s_end_of_input),
        .s_min_limit    (s_min_limit),
        .s_max_limit    (s_max_limit),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parsed_value (m_parsed_value),
        .m_status       (m_status),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // Append one character. Items the parser ignores while idle are not
    // counted toward the stream length.
    function automatic void push_char(bit start, logic [7:0] ch, bit at_eoi,
                                      logic signed [31:0] lo, logic signed [31:0] hi,
                                      bit live);
        ilp_pkg::item_t itm;
        itm.start_req    = start;
        itm.char_in      = ch;
        itm.end_of_input = at_eoi;
        itm.min_limit    = lo;
        itm.max_limit    = hi;
        char_q.push_back(itm);
        if (live) live_chars++;
    endfunction

    // Append a literal body. Bounds matter only on the first character; the
    // rest carry random bounds so that every bit of them toggles.
    function automatic void push_text(string txt, logic signed [31:0] lo,
                                      logic signed [31:0] hi);
        for (int i = 0; i < txt.len(); i++) begin
            if (i == 0) push_char(1'b1, txt[i], 1'b0, lo, hi, 1'b1);
            else        push_char(1'b0, txt[i], 1'b0, $urandom(), $urandom(), 1'b1);
        end
    endfunction

    // Terminate a literal: end of input with a junk byte, or any byte that
    // is not a hex digit.
    function automatic void push_end(bit at_eoi);
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (!at_eoi)
            while ((ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "f") ||
                   (ch >= "A" && ch <= "F"))
                ch = 8'($urandom_range(0, 255));
        push_char(1'b0, ch, at_eoi, $urandom(), $urandom(), 1'b1);
    endfunction

    // One random literal: sign, whitespace, prefix and digits, with the
    // magnitude often parked at the 32-bit edges or past them.
    task automatic gen_literal();
        string              txt;
        string              digits;
        longint unsigned    mag;
        logic signed [31:0] target;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        bit                 neg;
        bit                 terminated;
        byte unsigned       ws;
        case ($urandom_range(0, 3))
            0:       txt = "+";
            1:       txt = "-";
            default: txt = "";
        endcase
        neg = (txt == "-");
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) begin
                ws = 8'($urandom_range(8, 13));
                if (ws == 8) ws = " ";
                txt = $sformatf("%s%c", txt, ws);
            end
        case ($urandom_range(0, 9))
            0, 1, 2: mag = 64'($urandom_range(0, 99));
            3, 4:    mag = 64'($urandom_range(0, 99999));
            5:       mag = 64'($urandom());
            // straddle the positive limit and the magnitude of the negative one
            6, 7:    mag = 64'h7FFF_FFFE + 64'($urandom_range(0, 3));
            8:       mag = 64'hFFFF_FFFE + 64'($urandom_range(0, 3));
            default: mag = (longint'($urandom_range(1, 255)) << 32) | 64'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0: digits = $sformatf("0%0o", mag);
            1: begin
                digits = $sformatf("%0h", mag);
                // mix letter case
                for (int i = 0; i < digits.len(); i++)
                    if (digits[i] >= "a" && $urandom_range(0, 1))
                        digits[i] = digits[i] - 8'h20;
                if ($urandom_range(0, 1)) digits = {"0X", digits};
                else                      digits = {"0x", digits};
            end
            default: digits = $sformatf("%0d", mag);
        endcase
        txt = {txt, digits};
        // corrupt one character now and then
        if ($urandom_range(0, 7) == 0)
            txt[$urandom_range(0, txt.len() - 1)] = 8'($urandom_range(1, 255));

        target = neg ? -mag[31:0] : mag[31:0];
        case ($urandom_range(0, 5))
            3: begin
                lo = $urandom();
                hi = $urandom();
            end
            4: begin
                lo = target - $urandom_range(0, 2);
                hi = target + $urandom_range(0, 2);
            end
            5: begin
                lo = target + 1;
                hi = target + $urandom_range(1, 4);
            end
            default: begin
                lo = I32_LO;
                hi = I32_HI;
            end
        endcase
        push_text(txt, lo, hi);

        terminated = 1'b1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: push_end(1'b1);
            // leave it open; the next start abandons it
            9:             terminated = 1'b0;
            default:       push_end(1'b0);
        endcase
        // stray characters between literals, ignored by an idle parser
        if (terminated && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2))
                push_char(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          $urandom(), $urandom(), 1'b0);
    endtask

    // Sender: build the stream, release reset, then offer characters in
    // bursts with random gaps between them.
    initial begin
        ilp_pkg::item_t itm;
        int             gap;
        int             burst_left;

        // Directed part.
        push_char(1'b0, "5", 1'b0, I32_LO, I32_HI, 1'b0);  // idle character
        push_text("+\t7", I32_LO, I32_HI);                   // sign, whitespace
        push_end(1'b0);
        push_text("0x", I32_LO, I32_HI);                     // prefix, no digits
        push_char(1'b0, "g", 1'b0, I32_LO, I32_HI, 1'b1);
        push_text("09", I32_LO, I32_HI);                     // 9 is not octal
        push_text("0", I32_LO, I32_HI);                      // lone zero
        push_end(1'b1);
        push_text("-a", I32_LO, I32_HI);                     // letter in decimal
        push_text("5", 32'sd6, 32'sd9);                      // below the minimum
        push_end(1'b1);
        push_text("1", 32'sd5, 32'sd0);                      // crossed bounds
        push_end(1'b1);
        push_text("12", I32_LO, I32_HI);                     // abandoned by restart
        push_text("3", I32_LO, I32_HI);
        push_end(1'b1);
        push_char(1'b1, 8'h00, 1'b1, I32_LO, I32_HI, 1'b1); // start at end of input

        // Random part.
        while (live_chars < TARGET_CHARS)
            gen_literal();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        burst_left = 0;
        while (char_q.size() > 0) begin
            if (burst_left == 0) begin
                // a quarter of bursts follow on with no gap at all
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
            itm = char_q.pop_front();
            s_valid        <= 1'b1;
            s_start_req    <= itm.start_req;
            s_char_in      <= itm.char_in;
            s_end_of_input <= itm.end_of_input;
            s_min_limit    <= itm.min_limit;
            s_max_limit    <= itm.max_limit;
            burst_left--;
            // hold the payload until the transfer happens
            do @(posedge aclk); while (!s_ready);
            sent_count++;
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        // Drain: wait for every expected result, then let the pipe settle.
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: switch among random stall patterns, and once hold
    // off for a long stretch so the parser backs up into its input.
    initial begin
        rx_mode_t mode;
        int       mode_left;
        bit       held;
        mode      = RX_OPEN;
        mode_left = 0;
        held      = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held && sent_count >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (mode_left % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
